// ===== hdl/kht_pkg.sv =====
`default_nettype none

package kht_pkg;

	// Table geometry.
	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int USED_W      = $clog2(TABLE_DEPTH + 1);

	// Field widths fixed by the interface.
	localparam int CMD_W      = 2;
	localparam int KEY_W      = 64;
	localparam int SEL_W      = 6;
	localparam int STATUS_W   = 2;
	localparam int HITS_W     = 32;
	localparam int USED_OUT_W = 7;
	localparam int TOT_OUT_W  = 38;
	localparam int THR_W      = 32;
	localparam int FRAC_W     = 8;

	// Internal arithmetic widths.
	localparam int TOT_W   = HITS_W + USED_W;
	localparam int PROD_W  = THR_W + USED_W;
	localparam int USED_XW = (USED_W > USED_OUT_W) ? USED_W : USED_OUT_W;
	localparam int TOT_XW  = (TOT_W > TOT_OUT_W) ? TOT_W : TOT_OUT_W;

	localparam logic [HITS_W-1:0]     HITS_MAX = '1;
	localparam logic [USED_OUT_W-1:0] USED_SAT = '1;
	localparam logic [TOT_OUT_W-1:0]  TOT_SAT  = '1;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_COUNT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	typedef logic [KEY_W-1:0]  key_t;
	typedef logic [HITS_W-1:0] hits_t;

	// Outcome of a parallel key lookup.
	typedef struct packed {
		logic  found;
		hits_t slot_hits;
	} match_t;

endpackage

`default_nettype wire

// ===== hdl/kht_match.sv =====
`default_nettype none

// Parallel compare of one key against every stored slot. Stored keys are
// distinct, so at most one slot matches and the count is gathered by OR.
module kht_match (
	input  wire kht_pkg::key_t                  key,
	input  wire kht_pkg::key_t                  keys [kht_pkg::TABLE_DEPTH],
	input  wire kht_pkg::hits_t                 counts [kht_pkg::TABLE_DEPTH],
	input  wire [kht_pkg::TABLE_DEPTH-1:0]      valid,
	output logic [kht_pkg::TABLE_DEPTH-1:0]     hit_vec,
	output kht_pkg::match_t                     result
);

	always_comb begin
		hit_vec          = '0;
		result.found     = 1'b0;
		result.slot_hits = '0;
		for (int i = 0; i < kht_pkg::TABLE_DEPTH; i++) begin
			hit_vec[i]       = valid[i] && (keys[i] == key);
			result.found     = result.found | hit_vec[i];
			result.slot_hits = result.slot_hits | (counts[i] & {kht_pkg::HITS_W{hit_vec[i]}});
		end
	end

endmodule

`default_nettype wire

// ===== hdl/kmer_hit_counter_table_unit.sv =====
`default_nettype none

// K-mer hit counter table. The block holds up to 64 distinct 64-bit k-mer
// keys in a register table, each with a saturating 32-bit hit counter. A load
// command inserts a key (or clears the count of a key already present), a
// count command matches the key against all slots at once and bumps the
// matching counter, and a read command returns the key and count of one slot.
// Every result word also carries the number of stored keys, the sum of all
// counts and a positive flag that is set when the mean count per key is at or
// above positive_threshold (unsigned, 8 fraction bits); an empty table is
// positive only when the threshold is zero. The block accepts one word per
// cycle while out_stall does not hold the result register: one input
// register, then the lookup and table update, then the result register.
// A word makes a single pass through the key comparators and counter
// update, so back-to-back words see each other's updates with no hazard.
// Write positive_threshold only while no word is in flight.

module kmer_hit_counter_table_unit (
	input  wire                                  clk,
	input  wire                                  arst_n,

	input  wire                                  cfg_we,
	input  wire [kht_pkg::THR_W-1:0]             cfg_wdata,

	input  wire                                  in_valid,
	output logic                                 in_stall,
	input  wire [kht_pkg::CMD_W-1:0]             cmd,
	input  wire [kht_pkg::KEY_W-1:0]             kmer_key,
	input  wire [kht_pkg::SEL_W-1:0]             entry_index,

	output logic                                 out_valid,
	input  wire                                  out_stall,
	output logic [kht_pkg::STATUS_W-1:0]         status,
	output logic                                 hit,
	output logic [kht_pkg::KEY_W-1:0]            entry_key,
	output logic [kht_pkg::HITS_W-1:0]           entry_hits,
	output logic [kht_pkg::USED_OUT_W-1:0]       entries_used,
	output logic [kht_pkg::TOT_OUT_W-1:0]        total_hits,
	output logic                                 positive
);

	localparam int DEPTH = kht_pkg::TABLE_DEPTH;

	// Input stage.
	logic                          valid_s1;
	logic [kht_pkg::CMD_W-1:0]     cmd_s1;
	kht_pkg::key_t                 key_s1;
	logic [kht_pkg::SEL_W-1:0]     sel_s1;

	// Table state. Keys have no reset; a slot is only looked at once valid.
	kht_pkg::key_t                 key_q   [DEPTH];
	kht_pkg::hits_t                count_q [DEPTH];
	logic [DEPTH-1:0]              slot_valid_q;
	logic [kht_pkg::USED_W-1:0]    used_q;
	logic [kht_pkg::TOT_W-1:0]     total_q;
	logic [kht_pkg::THR_W-1:0]     thr_q;
	// Running product threshold * used_q, kept so the positive test needs
	// no multiplier in the item path.
	logic [kht_pkg::PROD_W-1:0]    prod_q;

	logic                          out_valid_q;

	logic                          in_fire;
	logic                          advance;
	logic [DEPTH-1:0]              hit_vec;
	kht_pkg::match_t               lookup;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_fire  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_s1 <= cmd;
			key_s1 <= kmer_key;
			sel_s1 <= entry_index;
		end
	end

	kht_match u_match (
		.key     (key_s1),
		.keys    (key_q),
		.counts  (count_q),
		.valid   (slot_valid_q),
		.hit_vec (hit_vec),
		.result  (lookup)
	);

	// Decode of the word in the input stage.
	logic is_load, is_count, is_read;
	logic table_full;
	logic do_insert, do_reload, do_bump;
	logic [kht_pkg::IDX_W-1:0] ins_slot;

	assign is_load    = (cmd_s1 == kht_pkg::CMD_LOAD);
	assign is_count   = (cmd_s1 == kht_pkg::CMD_COUNT);
	assign is_read    = (cmd_s1 == kht_pkg::CMD_READ);
	assign table_full = (used_q >= kht_pkg::USED_W'(DEPTH));
	assign ins_slot   = kht_pkg::IDX_W'(used_q);

	assign do_insert = advance && is_load && !lookup.found && !table_full;
	assign do_reload = advance && is_load && lookup.found;
	// A saturated counter still reports a hit but stays put.
	assign do_bump   = advance && is_count && lookup.found &&
	                   (lookup.slot_hits != kht_pkg::HITS_MAX);

	// Slot read for the read command. Slots beyond the index range read empty.
	logic            rd_found;
	kht_pkg::key_t   rd_key;
	kht_pkg::hits_t  rd_hits;

	always_comb begin
		rd_found = 1'b0;
		rd_key   = '0;
		rd_hits  = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if ((i < (1 << kht_pkg::SEL_W)) && (sel_s1 == kht_pkg::SEL_W'(i)) &&
			    slot_valid_q[i]) begin
				rd_found = 1'b1;
				rd_key   = key_q[i];
				rd_hits  = count_q[i];
			end
		end
	end

	// Summary values after this word's update.
	logic [kht_pkg::USED_W-1:0]         used_next;
	logic [kht_pkg::TOT_W-1:0]          total_next;
	logic [kht_pkg::PROD_W-1:0]         prod_next;
	logic [kht_pkg::TOT_W+kht_pkg::FRAC_W-1:0] scaled_total;
	logic                               pos_next;
	logic [kht_pkg::USED_XW-1:0]        used_wide;
	logic [kht_pkg::TOT_XW-1:0]         total_wide;

	always_comb begin
		used_next  = used_q + kht_pkg::USED_W'(do_insert);
		total_next = total_q + kht_pkg::TOT_W'(do_bump)
		             - (do_reload ? kht_pkg::TOT_W'(lookup.slot_hits) : '0);
		prod_next  = prod_q + (do_insert ? kht_pkg::PROD_W'(thr_q) : '0);
		scaled_total = {total_next, {kht_pkg::FRAC_W{1'b0}}};
		if (used_next == '0) begin
			pos_next = (thr_q == '0);
		end else begin
			pos_next = (scaled_total >=
			            (kht_pkg::TOT_W + kht_pkg::FRAC_W)'(prod_next));
		end
		used_wide  = kht_pkg::USED_XW'(used_next);
		total_wide = kht_pkg::TOT_XW'(total_next);
	end

	// Table update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			used_q       <= '0;
			total_q      <= '0;
			thr_q        <= '0;
			prod_q       <= '0;
			for (int i = 0; i < DEPTH; i++) begin
				count_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				thr_q  <= cfg_wdata;
				prod_q <= kht_pkg::PROD_W'(cfg_wdata) * kht_pkg::PROD_W'(used_q);
			end else begin
				prod_q <= prod_next;
			end
			used_q  <= used_next;
			total_q <= total_next;
			for (int i = 0; i < DEPTH; i++) begin
				if (do_reload && hit_vec[i]) begin
					count_q[i] <= '0;
				end else if (do_bump && hit_vec[i]) begin
					count_q[i] <= count_q[i] + kht_pkg::HITS_W'(1);
				end
				if (do_insert && (ins_slot == kht_pkg::IDX_W'(i))) begin
					slot_valid_q[i] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) begin
			if (do_insert && (ins_slot == kht_pkg::IDX_W'(i))) begin
				key_q[i] <= key_s1;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	logic [kht_pkg::STATUS_W-1:0]   status_q;
	logic                           hit_q;
	kht_pkg::key_t                  entry_key_q;
	kht_pkg::hits_t                 entry_hits_q;
	logic [kht_pkg::USED_OUT_W-1:0] entries_used_q;
	logic [kht_pkg::TOT_OUT_W-1:0]  total_hits_q;
	logic                           positive_q;

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q     <= kht_pkg::ST_OK;
			hit_q        <= 1'b0;
			entry_key_q  <= '0;
			entry_hits_q <= '0;
			if (is_load && !lookup.found && table_full) begin
				status_q <= kht_pkg::ST_FULL;
			end
			if (is_count && lookup.found) begin
				hit_q        <= 1'b1;
				entry_hits_q <= lookup.slot_hits + kht_pkg::HITS_W'(do_bump);
			end
			if (is_read) begin
				if (rd_found) begin
					entry_key_q  <= rd_key;
					entry_hits_q <= rd_hits;
				end else begin
					status_q <= kht_pkg::ST_EMPTY;
				end
			end
			entries_used_q <= (used_wide > kht_pkg::USED_XW'(kht_pkg::USED_SAT)) ?
			                  kht_pkg::USED_SAT : kht_pkg::USED_OUT_W'(used_wide);
			total_hits_q   <= (total_wide > kht_pkg::TOT_XW'(kht_pkg::TOT_SAT)) ?
			                  kht_pkg::TOT_SAT : kht_pkg::TOT_OUT_W'(total_wide);
			positive_q     <= pos_next;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign hit          = hit_q;
	assign entry_key    = entry_key_q;
	assign entry_hits   = entry_hits_q;
	assign entries_used = entries_used_q;
	assign total_hits   = total_hits_q;
	assign positive     = positive_q;

	// Stored keys are distinct, so a lookup never matches two slots.
	a_match_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> $onehot0(hit_vec))
		else $error("key lookup matched more than one slot");

	// Slots fill in order, so the valid bits count the used slots.
	a_fill_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(slot_valid_q) == used_q)
		else $error("slot valid bits disagree with fill count");

	// A count word that misses leaves the running total alone.
	a_miss_total: assert property (@(posedge clk) disable iff (!arst_n)
		advance && is_count && !lookup.found |=> $stable(total_q))
		else $error("total changed on a missed count");

	// A load never grows the table past its depth.
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= kht_pkg::USED_W'(DEPTH))
		else $error("fill count beyond table depth");

	// The product shadow tracks threshold times fill count.
	a_prod_track: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(cfg_we) |->
		prod_q == kht_pkg::PROD_W'(thr_q) * kht_pkg::PROD_W'(used_q))
		else $error("threshold product out of step");

endmodule

`default_nettype wire
